### design/iol_pkg.sv
// Package for the indexed ordered list: operation codes, status codes
// and the command word that the control logic broadcasts to every cell.
// No dependencies.
`default_nettype none

package iol_pkg;

    // Port widths fixed by the interface
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_APPEND  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PREPEND = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REMOVE  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ    = 3'd4;
    localparam logic [FUNC_W-1:0] FN_WALK    = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // Command broadcast to the cell chain
    typedef struct packed {
        logic ins;  // open a hole at pos and load the new value there
        logic rem;  // close the entry at pos, later entries move forward
    } cell_cmd_t;

endpackage

`default_nettype wire

### design/iol_cell.sv
// One storage cell of the list chain: holds one entry and takes its
// neighbor's value on insert or remove. Depends on iol_pkg.
`default_nettype none

module iol_cell #(
    parameter int EW  = 32,
    parameter int XW  = 5,
    parameter int IDX = 0
) (
    input  wire logic               aclk,
    input  wire iol_pkg::cell_cmd_t cmd,
    input  wire logic [XW-1:0]      pos,
    input  wire logic [XW-1:0]      sel,
    input  wire logic [EW-1:0]      new_value,
    input  wire logic [EW-1:0]      left_value,
    input  wire logic [EW-1:0]      right_value,
    output logic      [EW-1:0]      value,
    output logic      [EW-1:0]      sel_value
);

    localparam logic [XW-1:0] MY_IDX = XW'(IDX);

    logic [EW-1:0] value_reg;
    logic [EW-1:0] value_next;

    // Pick the next entry: hold, take a neighbor, or load the new value
    always_comb begin
        value_next = value_reg;
        if (cmd.ins) begin
            if (MY_IDX > pos) begin
                value_next = left_value;
            end else if (MY_IDX == pos) begin
                value_next = new_value;
            end
        end else if (cmd.rem) begin
            if (MY_IDX >= pos) begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value     = value_reg;
    // Drive the read bus only when this cell is addressed
    assign sel_value = (sel == MY_IDX) ? value_reg : '0;

endmodule

`default_nettype wire

### design/indexed_ordered_list.sv
// Indexed ordered list: append, prepend, insert, remove, read and walk.
// Timing: the result of an accepted item is registered and shows in the cycle
// after it; a walk first enters its walk state, then gives one element per
// cycle while m_ready is high. Throughput: one item per cycle while m_ready is
// high and no walk runs; each insert or remove shifts the cells from its position on by one place, all together.
// Reset: synchronous, active low; clears the length and control state only.
`default_nettype none

module indexed_ordered_list #(
    parameter int CAPACITY   = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_func,
    input  wire logic [4:0]  s_position,
    input  wire logic [31:0] s_item_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [31:0]      m_out_value,
    output logic [4:0]       m_length,
    output logic             m_last_of_run
);

    localparam int EW = ELEM_WIDTH;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > iol_pkg::POS_W) ? CW : iol_pkg::POS_W;
    localparam int OW = (EW > iol_pkg::VALUE_W) ? EW : iol_pkg::VALUE_W;
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [XW-1:0] walk_idx_reg, walk_idx_next;

    logic                          m_valid_reg;
    logic [iol_pkg::STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [iol_pkg::VALUE_W-1:0]   m_out_value_reg, m_out_value_next;
    logic [iol_pkg::LEN_W-1:0]     m_length_reg, m_length_next;
    logic                          m_last_reg, m_last_next;

    logic adv, accept, out_load, walk_start, walk_last;
    logic [XW-1:0] pos_x, cnt_x, cnt_next_x, cell_pos, sel;
    logic [OW-1:0] in_wide, rd_wide;
    logic [EW-1:0] new_value, rd_value;
    logic [iol_pkg::VALUE_W-1:0] rd_out;
    iol_pkg::cell_cmd_t cmd;

    logic [EW-1:0] cell_val [CAPACITY];
    logic [EW-1:0] sel_val  [CAPACITY];

    // Handshake: take an item when idle and the result slot frees up
    assign adv      = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && adv;
    assign accept   = s_valid && s_ready;

    assign pos_x     = XW'(s_position);
    assign cnt_x     = XW'(count_reg);
    assign in_wide   = OW'(s_item_value);
    assign new_value = in_wide[EW-1:0];
    assign sel       = (state_reg == ST_WALK) ? walk_idx_reg : pos_x;
    assign walk_last = (walk_idx_reg == XW'(cnt_x - XW'(1)));

    // Cell chain, front at cell 0
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [EW-1:0] left_v, right_v;
        if (g == 0) begin : g_front
            assign left_v = '0;
        end else begin : g_mid_l
            assign left_v = cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_back
            assign right_v = cell_val[g];
        end else begin : g_mid_r
            assign right_v = cell_val[g+1];
        end
        iol_cell #(
            .EW  (EW),
            .XW  (XW),
            .IDX (g)
        ) u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .pos         (cell_pos),
            .sel         (sel),
            .new_value   (new_value),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_val[g]),
            .sel_value   (sel_val[g])
        );
    end

    // Merge the read bus: at most one cell drives it
    always_comb begin
        rd_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_value = rd_value | sel_val[i];
        end
    end
    assign rd_wide = OW'(rd_value);
    assign rd_out  = rd_wide[iol_pkg::VALUE_W-1:0];

    // Decode the accepted item into a cell command and a result
    always_comb begin
        cmd              = '0;
        cell_pos         = pos_x;
        count_next       = count_reg;
        walk_start       = 1'b0;
        m_status_next    = iol_pkg::STAT_RANGE;
        m_out_value_next = '0;
        m_last_next      = 1'b1;
        if (accept) begin
            unique case (s_func) inside
                iol_pkg::FN_APPEND, iol_pkg::FN_PREPEND, iol_pkg::FN_INSERT: begin
                    if (cnt_x >= CAP_X) begin
                        m_status_next = iol_pkg::STAT_FULL;
                    end else if (s_func == iol_pkg::FN_INSERT && pos_x > cnt_x) begin
                        m_status_next = iol_pkg::STAT_RANGE;
                    end else begin
                        m_status_next = iol_pkg::STAT_OK;
                        cmd.ins       = 1'b1;
                        count_next    = count_reg + CW'(1);
                        if (s_func == iol_pkg::FN_APPEND) begin
                            cell_pos = cnt_x;
                        end else if (s_func == iol_pkg::FN_PREPEND) begin
                            cell_pos = '0;
                        end
                    end
                end
                iol_pkg::FN_REMOVE: begin
                    if (pos_x < cnt_x) begin
                        m_status_next    = iol_pkg::STAT_OK;
                        m_out_value_next = rd_out;
                        cmd.rem          = 1'b1;
                        count_next       = count_reg - CW'(1);
                    end
                end
                iol_pkg::FN_READ: begin
                    if (pos_x < cnt_x) begin
                        m_status_next    = iol_pkg::STAT_OK;
                        m_out_value_next = rd_out;
                    end
                end
                iol_pkg::FN_WALK: begin
                    walk_start = (cnt_x != '0);
                end
                default: begin
                    m_status_next = iol_pkg::STAT_RANGE;
                end
            endcase
        end else if (state_reg == ST_WALK) begin
            m_status_next    = iol_pkg::STAT_OK;
            m_out_value_next = rd_out;
            m_last_next      = walk_last;
        end
    end

    assign cnt_next_x    = XW'(count_next);
    assign m_length_next = cnt_next_x[iol_pkg::LEN_W-1:0];
    assign out_load      = (accept && !walk_start) || (state_reg == ST_WALK && adv);

    // Walk sequencer
    always_comb begin
        state_next    = state_reg;
        walk_idx_next = walk_idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (walk_start) begin
                    state_next    = ST_WALK;
                    walk_idx_next = '0;
                end
            end
            ST_WALK: begin
                if (adv) begin
                    walk_idx_next = walk_idx_reg + XW'(1);
                    if (walk_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            walk_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            walk_idx_reg <= walk_idx_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each new result
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg    <= m_status_next;
            m_out_value_reg <= m_out_value_next;
            m_length_reg    <= m_length_next;
            m_last_reg      <= m_last_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_out_value   = m_out_value_reg;
    assign m_length      = m_length_reg;
    assign m_last_of_run = m_last_reg;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_x <= CAP_X)
        else $error("list length beyond capacity");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> adv)
        else $error("pending result overwritten");

    a_ins_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the list by one");

    a_walk_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && adv && walk_last) |=> state_reg == ST_IDLE)
        else $error("walk did not end after its last element");

    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == iol_pkg::STAT_FULL) |-> m_out_value_reg == '0)
        else $error("full status with nonzero value");
`endif

endmodule

`default_nettype wire
